// ----- hdl/prq_pkg.sv -----
package prq_pkg;

  // Fixed field widths of the input and result beats.
  localparam int unsigned KindW    = 2;
  localparam int unsigned IdW      = 4;
  localparam int unsigned PrioW    = 5;
  localparam int unsigned RstateW  = 2;
  localparam int unsigned DcountW  = 16;
  localparam int unsigned WokenW   = 5;
  localparam int unsigned CountW   = 5;

  // Ready queue counts saturate here.
  localparam logic [CountW-1:0] CountMax = 5'd31;

  typedef enum logic [KindW-1:0] {
    KIND_ADD    = 2'd0,
    KIND_SWITCH = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_DELAY  = 2'd3
  } kind_e;

  // Any other runner state drops the runner.
  typedef enum logic [RstateW-1:0] {
    RS_REQUEUE = 2'd0,
    RS_RETIRE  = 2'd1,
    RS_DROP    = 2'd2
  } rstate_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_LVL,
    ST_ENQ_UPD,
    ST_PICK,
    ST_TICK,
    ST_DONE
  } state_e;

  typedef enum logic {
    ALU_DEC,
    ALU_GT
  } alu_op_e;

  typedef struct packed {
    logic zero;
    logic gt;
  } alu_flags_t;

endpackage

// ----- hdl/prq_in_if.sv -----
interface prq_in_if;
  logic                         valid;
  logic                         ready;
  logic [prq_pkg::KindW-1:0]    kind;
  logic [prq_pkg::IdW-1:0]      thread_id;
  logic [prq_pkg::PrioW-1:0]    priority_req;
  logic                         no_preempt;
  logic [prq_pkg::RstateW-1:0]  runner_state;
  logic [prq_pkg::DcountW-1:0]  delay_count;

  modport source (output valid, kind, thread_id, priority_req, no_preempt, runner_state,
                  delay_count, input ready);
  modport sink (input valid, kind, thread_id, priority_req, no_preempt, runner_state,
                delay_count, output ready);
endinterface

// ----- hdl/prq_out_if.sv -----
interface prq_out_if;
  logic                        valid;
  logic                        ready;
  logic [prq_pkg::IdW-1:0]     running_id;
  logic                        running_valid;
  logic                        preempt_request;
  logic [prq_pkg::WokenW-1:0]  woken_count;
  logic [prq_pkg::IdW-1:0]     retired_id;
  logic                        retired_valid;

  modport source (output valid, running_id, running_valid, preempt_request, woken_count,
                  retired_id, retired_valid, input ready);
  modport sink (input valid, running_id, running_valid, preempt_request, woken_count,
                retired_id, retired_valid, output ready);
endinterface

// ----- hdl/priority_ready_queue_scheduler_core.sv -----
// Priority scheduler with one FIFO ready queue per level, a bitmap of busy levels,
// a delay list and the running thread. One beat is taken at a time and yields one
// result beat. On a tick the shared decrement unit visits one delay list entry a
// cycle, but each wake-up halts the walk while it runs the enqueue states
// ENQ_LVL and ENQ_UPD. An empty ready set on switch leaves no thread running.
module priority_ready_queue_scheduler_core #(
  parameter int unsigned MAX_THREADS     = 16,
  parameter int unsigned PRIORITY_LEVELS = 32,
  parameter int unsigned DELAY_BITS      = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  prq_in_if.sink    in_i,
  prq_out_if.source out_o
);

  localparam int unsigned TIW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int unsigned LW  = $clog2(PRIORITY_LEVELS);
  localparam int unsigned DSW = $clog2(MAX_THREADS + 1);
  localparam int unsigned AW  = (DELAY_BITS > LW) ? DELAY_BITS : LW;
  localparam int unsigned IdW = prq_pkg::IdW;
  localparam int unsigned CW  = prq_pkg::CountW;

  // Highest set bit of the bitmap, with a found flag on top.
  function automatic logic [LW:0] top_level(input logic [PRIORITY_LEVELS-1:0] bm);
    logic [LW:0] r;
    r = '0;
    for (int k = 0; k < PRIORITY_LEVELS; k++) begin
      if (bm[k]) begin
        r = {1'b1, LW'(k)};
      end
    end
    return r;
  endfunction

  prq_pkg::state_e state_q, state_d, enq_ret_q;

  // Storage.
  logic [PRIORITY_LEVELS-1:0] bitmap_q;
  logic [CW-1:0]              queue_count_q [PRIORITY_LEVELS];
  logic [IdW-1:0]             queue_head [PRIORITY_LEVELS];
  logic [IdW-1:0]             queue_tail [PRIORITY_LEVELS];
  logic [IdW-1:0]             ready_next [MAX_THREADS];
  logic [LW-1:0]              thread_level [MAX_THREADS];
  logic [DELAY_BITS-1:0]      delay_left [MAX_THREADS];
  logic [IdW-1:0]             delay_next [MAX_THREADS];
  logic [IdW-1:0]             delay_first_q, delay_last_q;
  logic [DSW-1:0]             delay_size_q;
  logic [IdW-1:0]             runner_q;
  logic                       runner_valid_q;

  // Sequencer working registers.
  logic [IdW-1:0]             enq_t_q;
  logic                       protect_q;
  logic [LW-1:0]              lv_q;
  logic [IdW-1:0]             cur_q, prev_q;
  logic                       have_prev_q;
  logic [DSW-1:0]             n_q, i_q;
  logic                       preempt_q;
  logic [prq_pkg::WokenW-1:0] woken_q;
  logic [IdW-1:0]             ret_id_q;
  logic                       ret_valid_q;
  logic                       out_valid_q;

  // Result beat payload.
  logic [IdW-1:0]             o_running_id_q, o_retired_id_q;
  logic                       o_running_valid_q, o_preempt_q, o_retired_valid_q;
  logic [prq_pkg::WokenW-1:0] o_woken_q;

  // Decoded input beat.
  logic                       acc;
  logic [TIW-1:0]             tid_idx;
  logic                       tid_ok;
  logic [LW-1:0]              prio_sat;
  logic [DELAY_BITS-1:0]      dcount;
  logic                       add_ok, dly_ok;

  // Tick step and pick signals.
  logic [TIW-1:0]             cur_idx;
  logic [IdW-1:0]             nxt;
  logic                       tick_step, tick_nz, tick_exp;
  logic [LW:0]                top;
  logic [LW-1:0]              top_lv;
  logic                       pick_hit;

  // Shared unit.
  prq_pkg::alu_op_e           alu_op;
  logic [AW-1:0]              alu_a, alu_b, alu_res;
  prq_pkg::alu_flags_t        alu_flags;

  prq_alu #(.W(AW)) u_alu (
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .res_o  (alu_res),
    .flags_o(alu_flags)
  );

  // Input decode.
  assign in_i.ready = (state_q == prq_pkg::ST_IDLE) && !out_valid_q;
  assign acc        = in_i.valid && in_i.ready;
  assign tid_idx    = TIW'(in_i.thread_id);
  assign tid_ok     = (7'(in_i.thread_id) < 7'(MAX_THREADS));
  assign prio_sat   = (6'(in_i.priority_req) > 6'(PRIORITY_LEVELS - 1)) ?
                      LW'(PRIORITY_LEVELS - 1) : LW'(in_i.priority_req);
  assign dcount     = DELAY_BITS'(in_i.delay_count);
  assign add_ok     = acc && (in_i.kind == prq_pkg::KIND_ADD) && tid_ok;
  assign dly_ok     = acc && (in_i.kind == prq_pkg::KIND_DELAY) && tid_ok &&
                      (32'(delay_size_q) < 32'(MAX_THREADS));

  // Delay list walk and highest ready level.
  assign cur_idx   = TIW'(cur_q);
  assign nxt       = delay_next[cur_idx];
  assign tick_step = (state_q == prq_pkg::ST_TICK) && (i_q != n_q);
  assign tick_nz   = (delay_left[cur_idx] != '0);
  assign tick_exp  = tick_step && tick_nz && alu_flags.zero;
  assign top       = top_level(bitmap_q);
  assign top_lv    = top[LW-1:0];
  assign pick_hit  = top[LW];

  // Shared unit operands.
  always_comb begin
    alu_op = prq_pkg::ALU_GT;
    alu_a  = AW'(lv_q);
    alu_b  = AW'(thread_level[TIW'(runner_q)]);
    if (state_q == prq_pkg::ST_TICK) begin
      alu_op = prq_pkg::ALU_DEC;
      alu_a  = AW'(delay_left[cur_idx]);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      prq_pkg::ST_IDLE: begin
        if (acc) begin
          case (in_i.kind)
            prq_pkg::KIND_ADD:    state_d = tid_ok ? prq_pkg::ST_ENQ_LVL : prq_pkg::ST_DONE;
            prq_pkg::KIND_SWITCH: begin
              if (runner_valid_q && (in_i.runner_state == prq_pkg::RS_REQUEUE)) begin
                state_d = prq_pkg::ST_ENQ_LVL;
              end else begin
                state_d = prq_pkg::ST_PICK;
              end
            end
            prq_pkg::KIND_TICK:   state_d = prq_pkg::ST_TICK;
            default:              state_d = prq_pkg::ST_DONE;
          endcase
        end
      end
      prq_pkg::ST_ENQ_LVL: state_d = prq_pkg::ST_ENQ_UPD;
      prq_pkg::ST_ENQ_UPD: state_d = enq_ret_q;
      prq_pkg::ST_PICK:    state_d = prq_pkg::ST_DONE;
      prq_pkg::ST_TICK: begin
        if (!tick_step) begin
          state_d = prq_pkg::ST_DONE;
        end else if (tick_exp) begin
          state_d = prq_pkg::ST_ENQ_LVL;
        end
      end
      prq_pkg::ST_DONE:    state_d = prq_pkg::ST_IDLE;
      default:             state_d = prq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Thread, link and queue stores.
  always_ff @(posedge clk_i) begin
    if (add_ok || dly_ok) begin
      thread_level[tid_idx] <= prio_sat;
    end
    if (dly_ok) begin
      delay_left[tid_idx] <= dcount;
      // A thread already last in the list links to itself.
      if ((delay_size_q != '0) && (TIW'(delay_last_q) == tid_idx)) begin
        delay_next[tid_idx] <= in_i.thread_id;
      end else begin
        delay_next[tid_idx] <= '0;
        if (delay_size_q != '0) begin
          delay_next[TIW'(delay_last_q)] <= in_i.thread_id;
        end
      end
    end
    if (tick_step && tick_nz) begin
      delay_left[cur_idx] <= alu_res[DELAY_BITS-1:0];
      if (tick_exp && have_prev_q) begin
        delay_next[TIW'(prev_q)] <= nxt;
      end
    end
    if (state_q == prq_pkg::ST_ENQ_UPD) begin
      if (queue_count_q[lv_q] == '0) begin
        queue_head[lv_q] <= enq_t_q;
      end else begin
        ready_next[TIW'(queue_tail[lv_q])] <= enq_t_q;
      end
      queue_tail[lv_q] <= enq_t_q;
    end
    if ((state_q == prq_pkg::ST_PICK) && pick_hit && (queue_count_q[top_lv] != CW'(1))) begin
      queue_head[top_lv] <= ready_next[TIW'(queue_head[top_lv])];
    end
  end

  // Control state and sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_q       <= '0;
      for (int k = 0; k < PRIORITY_LEVELS; k++) begin
        queue_count_q[k] <= '0;
      end
      delay_first_q  <= '0;
      delay_last_q   <= '0;
      delay_size_q   <= '0;
      runner_q       <= '0;
      runner_valid_q <= 1'b0;
      enq_ret_q      <= prq_pkg::ST_DONE;
      enq_t_q        <= '0;
      protect_q      <= 1'b0;
      lv_q           <= '0;
      cur_q          <= '0;
      prev_q         <= '0;
      have_prev_q    <= 1'b0;
      n_q            <= '0;
      i_q            <= '0;
      preempt_q      <= 1'b0;
      woken_q        <= '0;
      ret_id_q       <= '0;
      ret_valid_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        prq_pkg::ST_IDLE: begin
          if (acc) begin
            preempt_q   <= 1'b0;
            woken_q     <= '0;
            cur_q       <= delay_first_q;
            have_prev_q <= 1'b0;
            prev_q      <= '0;
            n_q         <= delay_size_q;
            i_q         <= '0;
            // A switch with a valid runner and RS_REQUEUE requeues the runner, protected, before the pick.
            if (in_i.kind == prq_pkg::KIND_SWITCH) begin
              enq_ret_q <= prq_pkg::ST_PICK;
              enq_t_q   <= runner_q;
              protect_q <= 1'b1;
            end else begin
              enq_ret_q <= prq_pkg::ST_DONE;
              enq_t_q   <= in_i.thread_id;
              protect_q <= in_i.no_preempt;
            end
            if ((in_i.kind == prq_pkg::KIND_SWITCH) && runner_valid_q &&
                (in_i.runner_state == prq_pkg::RS_RETIRE)) begin
              ret_id_q    <= runner_q;
              ret_valid_q <= 1'b1;
            end else begin
              ret_id_q    <= '0;
              ret_valid_q <= 1'b0;
            end
            if (dly_ok) begin
              if (delay_size_q == '0) begin
                delay_first_q <= in_i.thread_id;
              end
              delay_last_q <= in_i.thread_id;
              delay_size_q <= delay_size_q + DSW'(1);
            end
          end
        end
        prq_pkg::ST_ENQ_LVL: begin
          lv_q <= thread_level[TIW'(enq_t_q)];
        end
        prq_pkg::ST_ENQ_UPD: begin
          if (queue_count_q[lv_q] < prq_pkg::CountMax) begin
            queue_count_q[lv_q] <= queue_count_q[lv_q] + CW'(1);
          end
          bitmap_q[lv_q] <= 1'b1;
          if (!protect_q && runner_valid_q && alu_flags.gt) begin
            preempt_q <= 1'b1;
          end
        end
        prq_pkg::ST_PICK: begin
          if (pick_hit) begin
            runner_q       <= queue_head[top_lv];
            runner_valid_q <= 1'b1;
            queue_count_q[top_lv] <= queue_count_q[top_lv] - CW'(1);
            if (queue_count_q[top_lv] == CW'(1)) begin
              bitmap_q[top_lv] <= 1'b0;
            end
          end else begin
            runner_q       <= '0;
            runner_valid_q <= 1'b0;
          end
        end
        prq_pkg::ST_TICK: begin
          if (tick_step) begin
            i_q   <= i_q + DSW'(1);
            cur_q <= nxt;
            if (tick_exp) begin
              if (!have_prev_q) begin
                delay_first_q <= nxt;
              end
              if (cur_q == delay_last_q) begin
                delay_last_q <= have_prev_q ? prev_q : '0;
              end
              delay_size_q <= delay_size_q - DSW'(1);
              woken_q      <= woken_q + prq_pkg::WokenW'(1);
              enq_t_q      <= cur_q;
              protect_q    <= 1'b0;
              enq_ret_q    <= prq_pkg::ST_TICK;
            end else begin
              prev_q      <= cur_q;
              have_prev_q <= 1'b1;
            end
          end else if (delay_size_q == '0) begin
            delay_first_q <= '0;
            delay_last_q  <= '0;
          end
        end
        prq_pkg::ST_DONE: begin
          out_valid_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Result beat payload.
  always_ff @(posedge clk_i) begin
    if (state_q == prq_pkg::ST_DONE) begin
      o_running_id_q    <= runner_valid_q ? runner_q : '0;
      o_running_valid_q <= runner_valid_q;
      o_preempt_q       <= preempt_q;
      o_woken_q         <= woken_q;
      o_retired_id_q    <= ret_id_q;
      o_retired_valid_q <= ret_valid_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.running_id      = o_running_id_q;
  assign out_o.running_valid   = o_running_valid_q;
  assign out_o.preempt_request = o_preempt_q;
  assign out_o.woken_count     = o_woken_q;
  assign out_o.retired_id      = o_retired_id_q;
  assign out_o.retired_valid   = o_retired_valid_q;

endmodule

// ----- hdl/prq_alu.sv -----
// Shared unit: decrements a delay and flags zero, or compares two levels.
module prq_alu #(
  parameter int unsigned W = 16
) (
  input  prq_pkg::alu_op_e    op_i,
  input  logic [W-1:0]        a_i,
  input  logic [W-1:0]        b_i,
  output logic [W-1:0]        res_o,
  output prq_pkg::alu_flags_t flags_o
);

  always_comb begin
    res_o        = a_i - W'(1);
    flags_o.zero = 1'b0;
    flags_o.gt   = 1'b0;
    case (op_i)
      prq_pkg::ALU_DEC: begin
        flags_o.zero = (res_o == '0);
      end
      prq_pkg::ALU_GT: begin
        flags_o.gt = (a_i > b_i);
      end
      default: begin
        flags_o.zero = 1'b0;
      end
    endcase
  end

endmodule

// ----- tb/priority_ready_queue_scheduler_core_test.sv -----
`timescale 1ns / 100ps

module priority_ready_queue_scheduler_core_test;

  localparam int unsigned NumThreads = 16;
  localparam int unsigned NumLevels  = 32;
  localparam int unsigned RandItems  = 500;
  localparam int unsigned QuietItems = 60;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [prq_pkg::IdW-1:0]    running_id;
    logic                       running_valid;
    logic                       preempt_request;
    logic [prq_pkg::WokenW-1:0] woken_count;
    logic [prq_pkg::IdW-1:0]    retired_id;
    logic                       retired_valid;
  } sched_res_t;

  typedef struct packed {
    prq_pkg::kind_e              kind;
    logic [prq_pkg::IdW-1:0]     thread_id;
    logic [prq_pkg::PrioW-1:0]   priority_req;
    logic                        no_preempt;
    logic [prq_pkg::RstateW-1:0] runner_state;
    logic [prq_pkg::DcountW-1:0] delay_count;
  } sched_op_t;

  typedef struct packed {
    sched_op_t  op;
    logic       fixed;
    sched_res_t res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  prq_in_if  in_if ();
  prq_out_if out_if ();

  priority_ready_queue_scheduler_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Clock.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Mirror of the scheduler state.
  logic [NumLevels-1:0]        lvl_map;
  logic [prq_pkg::IdW-1:0]     lvl_head [NumLevels];
  logic [prq_pkg::IdW-1:0]     lvl_tail [NumLevels];
  logic [prq_pkg::CountW-1:0]  lvl_count [NumLevels];
  logic [prq_pkg::IdW-1:0]     rdy_link [NumThreads];
  logic [prq_pkg::PrioW-1:0]   thr_level [NumThreads];
  logic [prq_pkg::DcountW-1:0] sleep_left [NumThreads];
  logic [prq_pkg::IdW-1:0]     sleep_link [NumThreads];
  logic [prq_pkg::IdW-1:0]     sleep_first;
  logic [prq_pkg::IdW-1:0]     sleep_last;
  logic [4:0]                  sleep_size;
  logic [prq_pkg::IdW-1:0]     cur_thread;
  logic                        cur_valid;

  sched_res_t pending_results[$];
  int unsigned taken_beats;
  int unsigned mismatches;
  int unsigned cycles;
  bit          quiet;
  bit          fixed_next;
  sched_res_t  fixed_res;

  // Queue a thread at its level; the result says whether it outranks the runner and is not protected.
  function automatic bit make_ready(logic [prq_pkg::IdW-1:0] t, bit protect);
    logic [prq_pkg::PrioW-1:0] lv;
    lv = thr_level[t];
    if (lvl_count[lv] == '0) lvl_head[lv] = t;
    else rdy_link[lvl_tail[lv]] = t;
    lvl_tail[lv] = t;
    if (lvl_count[lv] < prq_pkg::CountMax) lvl_count[lv] = lvl_count[lv] + 1'b1;
    lvl_map[lv] = 1'b1;
    return !protect && cur_valid && (lv > thr_level[cur_thread]);
  endfunction

  // Take the head of the highest busy level.
  function automatic void pick_runner();
    int lv;
    for (lv = NumLevels - 1; lv >= 0; lv--) if (lvl_map[lv]) break;
    if (lv < 0) begin
      cur_valid  = 1'b0;
      cur_thread = '0;
    end else begin
      cur_thread = lvl_head[lv];
      cur_valid  = 1'b1;
      lvl_count[lv] = lvl_count[lv] - 1'b1;
      if (lvl_count[lv] == '0) lvl_map[lv] = 1'b0;
      else lvl_head[lv] = rdy_link[cur_thread];
    end
  endfunction

  function automatic sched_res_t schedule_step(sched_op_t op);
    sched_res_t r;
    logic [prq_pkg::IdW-1:0] walk, prev, c, nxt;
    bit have_prev, removed;
    int n;
    r = '0;
    case (op.kind)
      prq_pkg::KIND_ADD: begin
        thr_level[op.thread_id] = op.priority_req;
        r.preempt_request = make_ready(op.thread_id, op.no_preempt);
      end
      prq_pkg::KIND_SWITCH: begin
        if (cur_valid) begin
          if (op.runner_state == prq_pkg::RS_REQUEUE) void'(make_ready(cur_thread, 1'b1));
          else if (op.runner_state == prq_pkg::RS_RETIRE) begin
            r.retired_id    = cur_thread;
            r.retired_valid = 1'b1;
          end
        end
        pick_runner();
      end
      prq_pkg::KIND_TICK: begin
        walk = sleep_first;
        prev = '0;
        have_prev = 1'b0;
        n = sleep_size;
        for (int i = 0; i < n; i++) begin
          c = walk;
          nxt = sleep_link[c];
          removed = 1'b0;
          if (sleep_left[c] != '0) begin
            sleep_left[c] = sleep_left[c] - 1'b1;
            if (sleep_left[c] == '0) begin
              if (have_prev) sleep_link[prev] = nxt;
              else sleep_first = nxt;
              if (c == sleep_last) sleep_last = have_prev ? prev : '0;
              sleep_size = sleep_size - 1'b1;
              removed = 1'b1;
              if (make_ready(c, 1'b0)) r.preempt_request = 1'b1;
              r.woken_count = r.woken_count + 1'b1;
            end
          end
          if (!removed) begin
            prev = c;
            have_prev = 1'b1;
          end
          walk = nxt;
        end
        if (sleep_size == '0) begin
          sleep_first = '0;
          sleep_last  = '0;
        end
      end
      default: begin
        if (sleep_size < NumThreads) begin
          thr_level[op.thread_id]  = op.priority_req;
          sleep_left[op.thread_id] = op.delay_count;
          sleep_link[op.thread_id] = '0;
          if (sleep_size == '0) sleep_first = op.thread_id;
          else sleep_link[sleep_last] = op.thread_id;
          sleep_last = op.thread_id;
          sleep_size = sleep_size + 1'b1;
        end
      end
    endcase
    r.running_id    = cur_valid ? cur_thread : '0;
    r.running_valid = cur_valid;
    return r;
  endfunction

  // Predict on every accepted input beat and check every result beat.
  always @(posedge clk_i) begin
    sched_res_t got, want, pred;
    sched_op_t  op;
    if (out_if.valid && out_if.ready) begin
      got = '{out_if.running_id, out_if.running_valid, out_if.preempt_request,
              out_if.woken_count, out_if.retired_id, out_if.retired_valid};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if (in_if.valid && in_if.ready) begin
      op = '{prq_pkg::kind_e'(in_if.kind), in_if.thread_id, in_if.priority_req,
             in_if.no_preempt, in_if.runner_state, in_if.delay_count};
      pred = schedule_step(op);
      pending_results.push_back(fixed_next ? fixed_res : pred);
      taken_beats++;
    end
  end

  // Run-away guard.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stalls in random bursts.
  initial begin
    int unsigned burst;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (burst != 0) burst--;
      else if (!quiet && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 15);
      out_if.ready = (burst == 0);
    end
  end

  // Hold one beat until it is taken.
  task automatic send_beat(sched_op_t op, bit fixed, sched_res_t res);
    int unsigned taken_mark;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_if.valid        = 1'b1;
    in_if.kind         = op.kind;
    in_if.thread_id    = op.thread_id;
    in_if.priority_req = op.priority_req;
    in_if.no_preempt   = op.no_preempt;
    in_if.runner_state = op.runner_state;
    in_if.delay_count  = op.delay_count;
    fixed_next = fixed;
    fixed_res  = res;
    taken_mark = taken_beats;
    do @(negedge clk_i); while (taken_beats == taken_mark);
  endtask

  function automatic sched_op_t random_op();
    sched_op_t op;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    op.kind = pick < 35 ? prq_pkg::KIND_ADD :
              pick < 60 ? prq_pkg::KIND_SWITCH :
              pick < 80 ? prq_pkg::KIND_TICK : prq_pkg::KIND_DELAY;
    op.thread_id    = prq_pkg::IdW'($urandom_range(0, NumThreads - 1));
    op.priority_req = ($urandom_range(0, 3) == 0) ? prq_pkg::PrioW'($urandom_range(0, 31))
                                                  : prq_pkg::PrioW'($urandom_range(0, 4) * 7);
    op.no_preempt   = 1'($urandom_range(0, 1));
    op.runner_state = prq_pkg::RstateW'($urandom_range(0, 3));
    pick = $urandom_range(0, 19);
    op.delay_count  = pick == 0 ? '0 :
                      pick == 1 ? prq_pkg::DcountW'($urandom_range(0, 65535))
                                : prq_pkg::DcountW'($urandom_range(1, 6));
    return op;
  endfunction

  // Directed rows: extremes, every operation and runner state.
  stim_row_t directed [] = '{
    '{'{prq_pkg::KIND_SWITCH, 4'd0, 5'd0, 1'b0, prq_pkg::RS_REQUEUE, 16'd0}, 1'b1, '0},
    '{'{prq_pkg::KIND_TICK, 4'd0, 5'd0, 1'b0, prq_pkg::RS_REQUEUE, 16'd0}, 1'b1, '0},
    '{'{prq_pkg::KIND_ADD, 4'd5, 5'd0, 1'b0, prq_pkg::RS_REQUEUE, 16'd0}, 1'b1, '0},
    '{'{prq_pkg::KIND_ADD, 4'd15, 5'd31, 1'b1, prq_pkg::RS_REQUEUE, 16'd0}, 1'b0, '0},
    '{'{prq_pkg::KIND_SWITCH, 4'd0, 5'd0, 1'b0, prq_pkg::RS_REQUEUE, 16'd0}, 1'b0, '0},
    '{'{prq_pkg::KIND_ADD, 4'd7, 5'd31, 1'b0, prq_pkg::RS_REQUEUE, 16'd0}, 1'b0, '0},
    '{'{prq_pkg::KIND_ADD, 4'd0, 5'd0, 1'b0, prq_pkg::RS_REQUEUE, 16'd0}, 1'b0, '0},
    '{'{prq_pkg::KIND_SWITCH, 4'd0, 5'd0, 1'b0, prq_pkg::RS_REQUEUE, 16'd0}, 1'b0, '0},
    '{'{prq_pkg::KIND_SWITCH, 4'd0, 5'd0, 1'b0, prq_pkg::RS_RETIRE, 16'd0}, 1'b0, '0},
    '{'{prq_pkg::KIND_SWITCH, 4'd0, 5'd0, 1'b0, prq_pkg::RS_DROP, 16'd0}, 1'b0, '0},
    '{'{prq_pkg::KIND_SWITCH, 4'd0, 5'd0, 1'b0, 2'd3, 16'd0}, 1'b0, '0},
    '{'{prq_pkg::KIND_SWITCH, 4'd0, 5'd0, 1'b0, prq_pkg::RS_RETIRE, 16'd0}, 1'b0, '0},
    '{'{prq_pkg::KIND_DELAY, 4'd2, 5'd1, 1'b0, prq_pkg::RS_REQUEUE, 16'd1}, 1'b0, '0},
    '{'{prq_pkg::KIND_DELAY, 4'd4, 5'd30, 1'b1, prq_pkg::RS_REQUEUE, 16'd0}, 1'b0, '0},
    '{'{prq_pkg::KIND_DELAY, 4'd6, 5'd16, 1'b0, prq_pkg::RS_REQUEUE, 16'hffff}, 1'b0, '0},
    '{'{prq_pkg::KIND_DELAY, 4'd1, 5'd8, 1'b0, prq_pkg::RS_REQUEUE, 16'd2}, 1'b0, '0},
    '{'{prq_pkg::KIND_TICK, 4'd0, 5'd0, 1'b0, prq_pkg::RS_REQUEUE, 16'd0}, 1'b0, '0},
    '{'{prq_pkg::KIND_SWITCH, 4'd0, 5'd0, 1'b0, prq_pkg::RS_REQUEUE, 16'd0}, 1'b0, '0},
    '{'{prq_pkg::KIND_TICK, 4'd0, 5'd0, 1'b0, prq_pkg::RS_REQUEUE, 16'd0}, 1'b0, '0},
    '{'{prq_pkg::KIND_SWITCH, 4'd0, 5'd0, 1'b0, prq_pkg::RS_REQUEUE, 16'd0}, 1'b0, '0}
  };

  // Stimulus.
  initial begin
    sched_op_t op;
    int unsigned wait_cycles;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = prq_pkg::KIND_ADD;
    in_if.thread_id = '0;
    in_if.priority_req = '0;
    in_if.no_preempt = 1'b0;
    in_if.runner_state = prq_pkg::RS_REQUEUE;
    in_if.delay_count = '0;
    lvl_map = '0;
    for (int i = 0; i < NumLevels; i++) begin
      lvl_head[i] = '0;
      lvl_tail[i] = '0;
      lvl_count[i] = '0;
    end
    for (int i = 0; i < NumThreads; i++) begin
      rdy_link[i] = '0;
      thr_level[i] = '0;
      sleep_left[i] = '0;
      sleep_link[i] = '0;
    end
    sleep_first = '0;
    sleep_last = '0;
    sleep_size = '0;
    cur_thread = '0;
    cur_valid = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_beat(directed[i].op, directed[i].fixed, directed[i].res);
    // Overflow the delay list, with a walking-one delay count and a varying thread and level.
    for (int i = 0; i < NumThreads + 1; i++) begin
      op = '{prq_pkg::KIND_DELAY, 4'(i), 5'(i * 3), 1'b0, prq_pkg::RS_REQUEUE,
             16'(1 << (i % 16))};
      send_beat(op, 1'b0, '0);
    end

    for (int i = 0; i < RandItems; i++) begin
      if (i == RandItems / 2) begin
        in_if.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk_i);
      end
      quiet = (i >= RandItems - QuietItems);
      send_beat(random_op(), 1'b0, '0);
    end
    in_if.valid = 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 5000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (80) @(negedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- priority_ready_queue_scheduler_core.f -----
hdl/prq_pkg.sv
hdl/prq_in_if.sv
hdl/prq_out_if.sv
hdl/prq_alu.sv
hdl/priority_ready_queue_scheduler_core.sv
tb/priority_ready_queue_scheduler_core_test.sv
